// ===== design/ssds_pkg.sv =====
// Package for the seven-segment digit scanner.
// Holds the segment table, command codes and the controller/datapath interface types.
// No dependencies.
`default_nettype none

package ssds_pkg;

  // Field widths fixed by the interface.
  localparam int FUNC_W     = 2;
  localparam int NUMBER_W   = 14;
  localparam int MODE_W     = 2;
  localparam int SEG_W      = 8;
  localparam int NUM_DIGITS = 4;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int IDX_W      = 2;
  localparam int CNT_W      = 3;
  localparam int STEP_W     = 4;

  // Value of the step count at the last shift step of the binary to BCD conversion.
  localparam logic [STEP_W-1:0] SHIFT_LAST = STEP_W'(NUMBER_W - 1);

  // Command codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_NUMBER = 2'd0,
    FUNC_MODE   = 2'd1,
    FUNC_END    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Letter patterns, bits g..a.
  localparam logic [SEG_W-1:0] SEG_C = 8'h39;
  localparam logic [SEG_W-1:0] SEG_D = 8'h5E;
  localparam logic [SEG_W-1:0] SEG_E = 8'h79;
  localparam logic [SEG_W-1:0] SEG_N = 8'h54;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_num;
    logic load_word;
    logic shift;
    logic fill;
    logic frame_first;
    logic frame_next;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic shift_last;
    logic frame_last;
  } dp_status_t;

  // Decimal digit to segment pattern; codes above nine show all segments lit.
  function automatic logic [SEG_W-1:0] digit_pattern(input logic [3:0] dig);
    logic [SEG_W-1:0] pat;
    unique case (dig)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'hFF;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ===== design/ssds_datapath.sv =====
// Datapath of the seven-segment digit scanner: clamp, shift-add-3 BCD conversion,
// pattern buffer and the registered frame output.
// Depends on ssds_pkg.
`default_nettype none

module ssds_datapath #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                                clk,
  input  ssds_pkg::dp_cmd_t                   cmd,
  input  logic [ssds_pkg::FUNC_W-1:0]         func,
  input  logic [ssds_pkg::NUMBER_W-1:0]       number,
  input  logic [ssds_pkg::MODE_W-1:0]         mode_value,
  output ssds_pkg::dp_status_t                status,
  output logic [ssds_pkg::SEG_W-1:0]          segments,
  output logic [ssds_pkg::NUM_DIGITS-1:0]     digit_select,
  output logic                                last
);
  import ssds_pkg::*;

  // Digits that the select field can address.
  localparam int USABLE = (DIGIT_COUNT > NUM_DIGITS) ? NUM_DIGITS :
                          ((DIGIT_COUNT < 1) ? 1 : DIGIT_COUNT);
  localparam int MAXVAL = (10 ** USABLE) - 1;
  localparam logic [NUMBER_W-1:0] MAX_NUM  = NUMBER_W'(MAXVAL);
  localparam logic [CNT_W-1:0]    CNT_MODE = CNT_W'((USABLE < 2) ? USABLE : 2);
  localparam logic [CNT_W-1:0]    CNT_END  = CNT_W'((USABLE < 3) ? USABLE : 3);

  logic [NUMBER_W-1:0] bin;
  logic [BCD_W-1:0]    bcd;
  logic [STEP_W-1:0]   shift_cnt;
  logic [SEG_W-1:0]    pats [NUM_DIGITS];
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    idx;

  logic [BCD_W-1:0]    bcd_adj;
  logic [CNT_W-1:0]    nd;
  logic [IDX_W-1:0]    fi;
  logic [3:0]          dig_src [NUM_DIGITS];

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  // Significant digit count; zero still shows one digit.
  always_comb begin
    if (bcd[15:12] != 4'd0) begin
      nd = 3'd4;
    end else if (bcd[11:8] != 4'd0) begin
      nd = 3'd3;
    end else if (bcd[7:4] != 4'd0) begin
      nd = 3'd2;
    end else begin
      nd = 3'd1;
    end
  end

  // Frame i shows the most significant digit first.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dig_src[i] = bcd[4 * IDX_W'(nd - 3'd1 - CNT_W'(i)) +: 4];
    end
  end

  // Index of the frame being loaded into the output register.
  assign fi = cmd.frame_next ? (idx + IDX_W'(1)) : '0;

  // Conversion registers.
  always_ff @(posedge clk) begin
    if (cmd.load_num) begin
      bin       <= (number > MAX_NUM) ? MAX_NUM : number;
      bcd       <= '0;
      shift_cnt <= '0;
    end else if (cmd.shift) begin
      {bcd, bin} <= {bcd_adj[BCD_W-2:0], bin, 1'b0};
      shift_cnt  <= shift_cnt + STEP_W'(1);
    end
  end

  // Pattern buffer and frame count.
  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      if (func == FUNC_MODE) begin
        pats[0] <= SEG_C;
        pats[1] <= digit_pattern({2'b00, mode_value});
        count   <= CNT_MODE;
      end else begin
        pats[0] <= SEG_E;
        pats[1] <= SEG_N;
        pats[2] <= SEG_D;
        count   <= CNT_END;
      end
    end else if (cmd.fill) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        pats[i] <= digit_pattern(dig_src[i]);
      end
      count <= nd;
    end
  end

  // Output frame register.
  always_ff @(posedge clk) begin
    if (cmd.frame_first || cmd.frame_next) begin
      idx          <= fi;
      segments     <= pats[fi];
      digit_select <= ~(NUM_DIGITS'(1) << fi);
      last         <= ((CNT_W'(fi) + CNT_W'(1)) == count);
    end
  end

  assign status.shift_last = (shift_cnt == SHIFT_LAST);
  assign status.frame_last = last;

endmodule

`default_nettype wire

// ===== design/ssds_ctrl.sv =====
// Controller of the seven-segment digit scanner: sequences load, conversion,
// buffer fill and frame delivery. Depends on ssds_pkg.
`default_nettype none

module ssds_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [ssds_pkg::FUNC_W-1:0]   func,
  input  logic                          out_ready,
  input  ssds_pkg::dp_status_t          status,
  output logic                          in_ready,
  output logic                          out_valid,
  output ssds_pkg::dp_cmd_t             cmd
);
  import ssds_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_FILL  = 5'b00100,
    ST_FRAME = 5'b01000,
    ST_SEND  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_xfer;
  logic   out_xfer;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_SEND);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (func) inside
            FUNC_NUMBER: begin
              cmd.load_num = 1'b1;
              state_next   = ST_CONV;
            end
            FUNC_MODE, FUNC_END: begin
              cmd.load_word = 1'b1;
              state_next    = ST_FRAME;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (status.shift_last) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.fill   = 1'b1;
        state_next = ST_FRAME;
      end
      ST_FRAME: begin
        cmd.frame_first = 1'b1;
        state_next      = ST_SEND;
      end
      ST_SEND: begin
        if (out_xfer) begin
          if (status.frame_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.frame_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/seven_segment_digit_scanner_core.sv =====
// Seven-segment digit scanner: one display command in, a run of digit-scan frames out.
// A number command runs its 14 shift-add-3 conversion steps and a buffer fill before
// its first frame is loaded; a word command goes straight to loading its first frame.
// Frames follow at one frame per cycle once started, while out_ready is held high; one
// command at a time. Reset returns the controller to idle with no frame pending.
`default_nettype none

module seven_segment_digit_scanner_core #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ssds_pkg::FUNC_W-1:0]         func,
  input  logic [ssds_pkg::NUMBER_W-1:0]       number,
  input  logic [ssds_pkg::MODE_W-1:0]         mode_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ssds_pkg::SEG_W-1:0]          segments,
  output logic [ssds_pkg::NUM_DIGITS-1:0]     digit_select,
  output logic                                last
);
  import ssds_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  ssds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .func      (func),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Conversion and frame registers.
  ssds_datapath #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .func         (func),
    .number       (number),
    .mode_value   (mode_value),
    .status       (status),
    .segments     (segments),
    .digit_select (digit_select),
    .last         (last)
  );

endmodule

`default_nettype wire

// ===== design/ssds_checker.sv =====
// Port-level checks for the seven-segment digit scanner, bound to the top level.
// Depends on ssds_pkg.
`default_nettype none

module ssds_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [ssds_pkg::SEG_W-1:0]          segments,
  input logic [ssds_pkg::NUM_DIGITS-1:0]     digit_select,
  input logic                                last
);
  import ssds_pkg::*;

  // A shown frame holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(segments) &&
                                   $stable(digit_select) && $stable(last)))
    else $error("frame changed before transfer");

  // Exactly one digit is enabled in every frame.
  a_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(~digit_select))
    else $error("digit select not one-hot low");

  // No new command is taken while a frame is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while frame pending");

  // A run continues with the next frame at once until its last frame.
  a_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> (out_valid && !in_ready))
    else $error("run ended before its last frame");

endmodule

bind seven_segment_digit_scanner_core ssds_checker u_ssds_checker (.*);

`default_nettype wire
